// ===== rtl/rmj_pkg.sv =====
// Shared widths, job records and the saturating pack function for the radar
// measurement Jacobian. No dependencies.
package rmj_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int SQ_W      = 2 * DATA_W;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int C_W       = 2 * DATA_W;
   localparam int QUO_W     = DATA_W;
   localparam int DEN_W     = SQ_W + ROOT_W;
   localparam int NUM_W     = DATA_W + C_W + FRAC_BITS;
   localparam int SQRT_N    = ROOT_W;
   localparam int RREM_W    = ROOT_W + 3;
   localparam int MIN_W     = 16;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int N_OUT     = 6;
   localparam int REQ_W     = 4 * DATA_W;
   localparam int RSP_W     = N_OUT * DATA_W;
   localparam int USER_W    = 2;

   typedef struct packed {
      logic [DATA_W-1:0] ap;
      logic [DATA_W-1:0] aq;
      logic              pneg;
      logic              qneg;
      logic              qpos;
      logic [SQ_W-1:0]   s;
      logic [ROOT_W-1:0] r;
      logic [C_W-1:0]    ac;
      logic              cneg;
      logic              too_close;
   } job_type;

   typedef struct packed {
      logic pneg;
      logic qneg;
      logic qpos;
      logic neg4;
      logic neg5;
      logic too_close;
   } side_type;

   function automatic logic [DATA_W:0] rmj_pack(input logic [QUO_W-1:0] q,
                                                input logic ovf, input logic neg);
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] v;
      logic              sat;
      lim = neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      sat = ovf || (q > lim);
      v   = sat ? lim : q;
      return {sat, (neg ? (~v + 1'b1) : v)};
   endfunction

endpackage

// ===== rtl/rmj_div_lane.sv =====
// Pipelined restoring divider lane: one quotient bit per stage, overflow
// check up front. Depends on rmj_pkg.
module rmj_div_lane (
   input  logic                         clock,
   input  logic                         en,
   input  logic [rmj_pkg::NUM_W-1:0]    num,
   input  logic [rmj_pkg::DEN_W-1:0]    den,
   output logic [rmj_pkg::QUO_W-1:0]    quo,
   output logic                         ovf
);

   logic [rmj_pkg::NUM_W-rmj_pkg::QUO_W-1:0] hi_w;
   logic [rmj_pkg::DEN_W-1:0]                hi_ext_w;
   logic                                     ovf0_w;

   logic [rmj_pkg::DEN_W-1:0] rem_ff [0:rmj_pkg::QUO_W];
   logic [rmj_pkg::DEN_W-1:0] d_ff   [0:rmj_pkg::QUO_W];
   logic [rmj_pkg::QUO_W-1:0] nlo_ff [0:rmj_pkg::QUO_W];
   logic [rmj_pkg::QUO_W-1:0] q_ff   [0:rmj_pkg::QUO_W];
   logic                      ovf_ff [0:rmj_pkg::QUO_W];

   logic [rmj_pkg::DEN_W:0]   t_w    [1:rmj_pkg::QUO_W];
   logic [rmj_pkg::DEN_W:0]   diff_w [1:rmj_pkg::QUO_W];
   logic                      ge_w   [1:rmj_pkg::QUO_W];

   assign hi_w     = num[rmj_pkg::NUM_W-1:rmj_pkg::QUO_W];
   assign hi_ext_w = {{(rmj_pkg::DEN_W-rmj_pkg::NUM_W+rmj_pkg::QUO_W){1'b0}}, hi_w};
   assign ovf0_w   = hi_ext_w >= den;

   always_comb begin
      for (int k = 1; k <= rmj_pkg::QUO_W; k++) begin
         t_w[k]    = {rem_ff[k-1], nlo_ff[k-1][rmj_pkg::QUO_W-1]};
         ge_w[k]   = t_w[k] >= {1'b0, d_ff[k-1]};
         diff_w[k] = t_w[k] - {1'b0, d_ff[k-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ovf0_w ? '0 : hi_ext_w;
         d_ff[0]   <= den;
         nlo_ff[0] <= num[rmj_pkg::QUO_W-1:0];
         q_ff[0]   <= '0;
         ovf_ff[0] <= ovf0_w;
         for (int k = 1; k <= rmj_pkg::QUO_W; k++) begin
            rem_ff[k] <= ge_w[k] ? diff_w[k][rmj_pkg::DEN_W-1:0]
                                 : t_w[k][rmj_pkg::DEN_W-1:0];
            d_ff[k]   <= d_ff[k-1];
            nlo_ff[k] <= {nlo_ff[k-1][rmj_pkg::QUO_W-2:0], 1'b0};
            q_ff[k]   <= {q_ff[k-1][rmj_pkg::QUO_W-2:0], ge_w[k]};
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = q_ff[rmj_pkg::QUO_W];
   assign ovf = ovf_ff[rmj_pkg::QUO_W];

endmodule

// ===== rtl/rmj_front.sv =====
// Front end: takes state words, forms squares and the cross term, runs the
// pipelined integer square root and flags short range. Depends on rmj_pkg.
module rmj_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [rmj_pkg::REQ_W-1:0]   req_tdata,
   input  logic [rmj_pkg::MIN_W-1:0]   min_range,
   input  logic                        q_full,
   output logic                        push,
   output rmj_pkg::job_type            push_job
);

   logic en_w;

   logic                       a_v_ff;
   logic [rmj_pkg::DATA_W-1:0] px_ff, py_ff, vx_ff, vy_ff;

   logic                       b_v_ff;
   logic [rmj_pkg::DATA_W-1:0] ap_ff, aq_ff;
   logic                       pneg_ff, qneg_ff, qpos_ff;
   logic [rmj_pkg::SQ_W-1:0]   pp_ff, qq_ff, vq_ff, vp_ff;

   logic [rmj_pkg::DATA_W-1:0] ap_w, aq_w;
   logic [rmj_pkg::SQ_W-1:0]   pp_w, qq_w;
   logic signed [rmj_pkg::SQ_W-1:0] vq_w, vp_w;
   logic [rmj_pkg::SQ_W:0]     c_w;
   logic [rmj_pkg::SQ_W:0]     cmag_w;

   logic                        v_ff    [0:rmj_pkg::SQRT_N];
   rmj_pkg::job_type            job_ff  [0:rmj_pkg::SQRT_N];
   logic [rmj_pkg::RREM_W-1:0]  rem_ff  [0:rmj_pkg::SQRT_N];
   logic [rmj_pkg::ROOT_W-1:0]  root_ff [0:rmj_pkg::SQRT_N];

   logic [rmj_pkg::RREM_W-1:0]  t_w     [1:rmj_pkg::SQRT_N];
   logic [rmj_pkg::RREM_W-1:0]  trial_w [1:rmj_pkg::SQRT_N];
   logic                        ge_w    [1:rmj_pkg::SQRT_N];

   assign en_w       = !q_full;
   assign req_tready = en_w;

   assign ap_w = px_ff[rmj_pkg::DATA_W-1] ? (~px_ff + 1'b1) : px_ff;
   assign aq_w = py_ff[rmj_pkg::DATA_W-1] ? (~py_ff + 1'b1) : py_ff;
   assign pp_w = ap_w * ap_w;
   assign qq_w = aq_w * aq_w;
   assign vq_w = $signed(vx_ff) * $signed(py_ff);
   assign vp_w = $signed(vy_ff) * $signed(px_ff);

   assign c_w    = {vq_ff[rmj_pkg::SQ_W-1], vq_ff} - {vp_ff[rmj_pkg::SQ_W-1], vp_ff};
   assign cmag_w = c_w[rmj_pkg::SQ_W] ? (~c_w + 1'b1) : c_w;

   always_comb begin
      for (int k = 1; k <= rmj_pkg::SQRT_N; k++) begin
         t_w[k]     = {rem_ff[k-1][rmj_pkg::RREM_W-3:0],
                       job_ff[k-1].s[2*(rmj_pkg::SQRT_N-k) +: 2]};
         trial_w[k] = {1'b0, root_ff[k-1], 2'b01};
         ge_w[k]    = t_w[k] >= trial_w[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         for (int k = 0; k <= rmj_pkg::SQRT_N; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en_w) begin
         a_v_ff <= req_tvalid;
         b_v_ff <= a_v_ff;
         v_ff[0] <= b_v_ff;
         for (int k = 1; k <= rmj_pkg::SQRT_N; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_w) begin
         px_ff <= req_tdata[0*rmj_pkg::DATA_W +: rmj_pkg::DATA_W];
         py_ff <= req_tdata[1*rmj_pkg::DATA_W +: rmj_pkg::DATA_W];
         vx_ff <= req_tdata[2*rmj_pkg::DATA_W +: rmj_pkg::DATA_W];
         vy_ff <= req_tdata[3*rmj_pkg::DATA_W +: rmj_pkg::DATA_W];

         ap_ff   <= ap_w;
         aq_ff   <= aq_w;
         pneg_ff <= px_ff[rmj_pkg::DATA_W-1];
         qneg_ff <= py_ff[rmj_pkg::DATA_W-1];
         qpos_ff <= !py_ff[rmj_pkg::DATA_W-1] && (py_ff != '0);
         pp_ff   <= pp_w;
         qq_ff   <= qq_w;
         vq_ff   <= vq_w;
         vp_ff   <= vp_w;

         job_ff[0].ap        <= ap_ff;
         job_ff[0].aq        <= aq_ff;
         job_ff[0].pneg      <= pneg_ff;
         job_ff[0].qneg      <= qneg_ff;
         job_ff[0].qpos      <= qpos_ff;
         job_ff[0].s         <= pp_ff + qq_ff;
         job_ff[0].r         <= '0;
         job_ff[0].ac        <= cmag_w[rmj_pkg::C_W-1:0];
         job_ff[0].cneg      <= c_w[rmj_pkg::SQ_W];
         job_ff[0].too_close <= 1'b0;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         for (int k = 1; k <= rmj_pkg::SQRT_N; k++) begin
            job_ff[k]  <= job_ff[k-1];
            rem_ff[k]  <= ge_w[k] ? (t_w[k] - trial_w[k]) : t_w[k];
            root_ff[k] <= {root_ff[k-1][rmj_pkg::ROOT_W-2:0], ge_w[k]};
         end
      end
   end

   always_comb begin
      push_job           = job_ff[rmj_pkg::SQRT_N];
      push_job.r         = root_ff[rmj_pkg::SQRT_N];
      push_job.too_close = (root_ff[rmj_pkg::SQRT_N] == '0) ||
                           (root_ff[rmj_pkg::SQRT_N] <
                            {{(rmj_pkg::ROOT_W-rmj_pkg::MIN_W){1'b0}}, min_range});
   end

   assign push = en_w && v_ff[rmj_pkg::SQRT_N];

endmodule

// ===== rtl/rmj_queue.sv =====
// Short job queue between the front and back ends. Depends on rmj_pkg.
module rmj_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmj_pkg::job_type push_job,
   input  logic             pop,
   output rmj_pkg::job_type pop_job,
   output logic             full,
   output logic             empty
);

   rmj_pkg::job_type          slot_ff [0:rmj_pkg::QDEPTH-1];
   logic [rmj_pkg::QPTR_W-1:0] wr_ff, rd_ff;
   logic [rmj_pkg::QPTR_W:0]   cnt_ff, cnt_in;

   assign full    = cnt_ff == (rmj_pkg::QPTR_W+1)'(rmj_pkg::QDEPTH);
   assign empty   = cnt_ff == '0;
   assign pop_job = slot_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/rmj_back.sv =====
// Back end: forms numerators and divisors, runs six divider lanes, saturates
// and holds the result word in an output register with a skid slot.
// Depends on rmj_pkg and rmj_div_lane.
module rmj_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  rmj_pkg::job_type            pop_job,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [rmj_pkg::RSP_W-1:0]   rsp_tdata,
   output logic [rmj_pkg::USER_W-1:0]  rsp_tuser
);

   localparam int WORD_W = rmj_pkg::RSP_W + rmj_pkg::USER_W;
   localparam int DW     = rmj_pkg::DATA_W;

   logic en_w;

   logic             b0_v_ff;
   rmj_pkg::job_type b0_ff;

   logic                      b1_v_ff;
   rmj_pkg::side_type         b1_side_ff;
   logic [DW-1:0]             b1_ap_ff, b1_aq_ff;
   logic [rmj_pkg::SQ_W-1:0]  b1_s_ff;
   logic [rmj_pkg::ROOT_W-1:0] b1_r_ff;
   logic [2*DW-1:0]           mq_lo_ff, mq_hi_ff, mp_lo_ff, mp_hi_ff, sr_lo_ff, sr_hi_ff;

   logic                      b2_v_ff;
   rmj_pkg::side_type         b2_side_ff;
   logic [rmj_pkg::NUM_W-1:0] n_ff [0:rmj_pkg::N_OUT-1];
   logic [rmj_pkg::DEN_W-1:0] d_ff [0:rmj_pkg::N_OUT-1];

   logic [rmj_pkg::DEN_W-1:0] nq_w, np_w, sr_w;

   logic                      v_ff    [0:rmj_pkg::QUO_W];
   rmj_pkg::side_type         side_ff [0:rmj_pkg::QUO_W];

   logic [rmj_pkg::QUO_W-1:0] quo_w [0:rmj_pkg::N_OUT-1];
   logic                      ovf_w [0:rmj_pkg::N_OUT-1];
   logic                      neg_w [0:rmj_pkg::N_OUT-1];
   logic [DW:0]               pk_w  [0:rmj_pkg::N_OUT-1];

   rmj_pkg::side_type         tail_side_w;
   logic                      tail_v_w;
   logic [WORD_W-1:0]         tail_w;
   logic                      sat_w;

   logic                      out_v_ff, sk_v_ff;
   logic [WORD_W-1:0]         out_ff, sk_ff;

   assign en_w = !sk_v_ff;
   assign pop  = en_w && !q_empty;

   assign nq_w = {mq_hi_ff, {DW{1'b0}}} + {{DW{1'b0}}, mq_lo_ff};
   assign np_w = {mp_hi_ff, {DW{1'b0}}} + {{DW{1'b0}}, mp_lo_ff};
   assign sr_w = {sr_hi_ff, {DW{1'b0}}} + {{DW{1'b0}}, sr_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_v_ff <= 1'b0;
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         for (int k = 0; k <= rmj_pkg::QUO_W; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en_w) begin
         b0_v_ff <= !q_empty;
         b1_v_ff <= b0_v_ff;
         b2_v_ff <= b1_v_ff;
         v_ff[0] <= b2_v_ff;
         for (int k = 1; k <= rmj_pkg::QUO_W; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_w) begin
         b0_ff <= pop_job;

         b1_side_ff.pneg      <= b0_ff.pneg;
         b1_side_ff.qneg      <= b0_ff.qneg;
         b1_side_ff.qpos      <= b0_ff.qpos;
         b1_side_ff.neg4      <= (b0_ff.qneg != b0_ff.cneg) && (b0_ff.aq != '0) &&
                                 (b0_ff.ac != '0);
         b1_side_ff.neg5      <= (b0_ff.pneg == b0_ff.cneg) && (b0_ff.ap != '0) &&
                                 (b0_ff.ac != '0);
         b1_side_ff.too_close <= b0_ff.too_close;
         b1_ap_ff <= b0_ff.ap;
         b1_aq_ff <= b0_ff.aq;
         b1_s_ff  <= b0_ff.s;
         b1_r_ff  <= b0_ff.r;
         mq_lo_ff <= b0_ff.aq * b0_ff.ac[DW-1:0];
         mq_hi_ff <= b0_ff.aq * b0_ff.ac[2*DW-1:DW];
         mp_lo_ff <= b0_ff.ap * b0_ff.ac[DW-1:0];
         mp_hi_ff <= b0_ff.ap * b0_ff.ac[2*DW-1:DW];
         sr_lo_ff <= b0_ff.s[DW-1:0] * b0_ff.r;
         sr_hi_ff <= b0_ff.s[2*DW-1:DW] * b0_ff.r;

         b2_side_ff <= b1_side_ff;
         n_ff[0] <= {{(rmj_pkg::NUM_W-DW){1'b0}}, b1_ap_ff} << rmj_pkg::FRAC_BITS;
         n_ff[1] <= {{(rmj_pkg::NUM_W-DW){1'b0}}, b1_aq_ff} << rmj_pkg::FRAC_BITS;
         n_ff[2] <= {{(rmj_pkg::NUM_W-DW){1'b0}}, b1_aq_ff} << (2*rmj_pkg::FRAC_BITS);
         n_ff[3] <= {{(rmj_pkg::NUM_W-DW){1'b0}}, b1_ap_ff} << (2*rmj_pkg::FRAC_BITS);
         n_ff[4] <= {{(rmj_pkg::NUM_W-rmj_pkg::DEN_W){1'b0}}, nq_w} << rmj_pkg::FRAC_BITS;
         n_ff[5] <= {{(rmj_pkg::NUM_W-rmj_pkg::DEN_W){1'b0}}, np_w} << rmj_pkg::FRAC_BITS;
         d_ff[0] <= {{(rmj_pkg::DEN_W-rmj_pkg::ROOT_W){1'b0}}, b1_r_ff};
         d_ff[1] <= {{(rmj_pkg::DEN_W-rmj_pkg::ROOT_W){1'b0}}, b1_r_ff};
         d_ff[2] <= {{(rmj_pkg::DEN_W-rmj_pkg::SQ_W){1'b0}}, b1_s_ff};
         d_ff[3] <= {{(rmj_pkg::DEN_W-rmj_pkg::SQ_W){1'b0}}, b1_s_ff};
         d_ff[4] <= sr_w;
         d_ff[5] <= sr_w;

         side_ff[0] <= b2_side_ff;
         for (int k = 1; k <= rmj_pkg::QUO_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar j = 0; j < rmj_pkg::N_OUT; j++) begin : g_lane
      rmj_div_lane u_lane (
         .clock (clock),
         .en    (en_w),
         .num   (n_ff[j]),
         .den   (d_ff[j]),
         .quo   (quo_w[j]),
         .ovf   (ovf_w[j])
      );
   end

   assign tail_side_w = side_ff[rmj_pkg::QUO_W];
   assign tail_v_w    = v_ff[rmj_pkg::QUO_W];

   always_comb begin
      neg_w[0] = tail_side_w.pneg;
      neg_w[1] = tail_side_w.qneg;
      neg_w[2] = tail_side_w.qpos;
      neg_w[3] = tail_side_w.pneg;
      neg_w[4] = tail_side_w.neg4;
      neg_w[5] = tail_side_w.neg5;
      sat_w    = 1'b0;
      tail_w   = '0;
      for (int j = 0; j < rmj_pkg::N_OUT; j++) begin
         pk_w[j] = rmj_pkg::rmj_pack(quo_w[j], ovf_w[j], neg_w[j]);
         tail_w[j*DW +: DW] = pk_w[j][DW-1:0];
         sat_w = sat_w | pk_w[j][DW];
      end
      tail_w[rmj_pkg::RSP_W +: rmj_pkg::USER_W] = {sat_w, 1'b0};
      if (tail_side_w.too_close) begin
         tail_w = '0;
         tail_w[rmj_pkg::RSP_W] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         out_v_ff <= sk_v_ff || (tail_v_w && en_w);
         sk_v_ff  <= 1'b0;
      end else if (tail_v_w && en_w) begin
         sk_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= sk_v_ff ? sk_ff : tail_w;
      end else if (tail_v_w && en_w) begin
         sk_ff <= tail_w;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_ff[rmj_pkg::RSP_W-1:0];
   assign rsp_tuser  = out_ff[rmj_pkg::RSP_W +: rmj_pkg::USER_W];

endmodule

// ===== rtl/radar_measurement_jacobian.sv =====
// Radar measurement Jacobian: one state word (px, py, vx, vy, Q16.16) in, one
// word of six saturated Jacobian entries plus flags out, one word per clock
// cycle sustained unless rsp_tready stalls the output. The front end runs a
// 32-stage square-root pipeline and the back end 33-stage divider lanes, with
// a four-word queue between them so each end stalls on its own. Entries are
// truncated toward zero; too_close forces zeros when the integer range is zero
// or below min_range. Depends on rmj_pkg, rmj_front, rmj_queue and rmj_back.
module radar_measurement_jacobian (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pos_x, pos_y, vel_x, vel_y
   input  logic [rmj_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy
   output logic [rmj_pkg::RSP_W-1:0]   rsp_tdata,
   // too_close, saturated
   output logic [rmj_pkg::USER_W-1:0]  rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [rmj_pkg::MIN_W-1:0]   csr_data
);

   logic [rmj_pkg::MIN_W-1:0] min_range_ff;
   logic                      push, pop, q_full, q_empty;
   rmj_pkg::job_type          push_job, pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= rmj_pkg::MIN_W'(1);
      end else if (csr_valid) begin
         min_range_ff <= csr_data;
      end
   end

   rmj_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .min_range  (min_range_ff),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   rmj_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   rmj_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop_job    (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/rmj_checker.sv =====
// Port-level checks on the result stream, bound to the top level.
// Depends on rmj_pkg.
module rmj_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [rmj_pkg::RSP_W-1:0]   rsp_tdata,
   input logic [rmj_pkg::USER_W-1:0]  rsp_tuser
);

   logic extreme_w;

   always_comb begin
      extreme_w = 1'b0;
      for (int j = 0; j < rmj_pkg::N_OUT; j++) begin
         if ((rsp_tdata[j*rmj_pkg::DATA_W +: rmj_pkg::DATA_W] ==
              {1'b0, {(rmj_pkg::DATA_W-1){1'b1}}}) ||
             (rsp_tdata[j*rmj_pkg::DATA_W +: rmj_pkg::DATA_W] ==
              {1'b1, {(rmj_pkg::DATA_W-1){1'b0}}})) begin
            extreme_w = 1'b1;
         end
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result word changed");

   a_close_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> !rsp_tuser[1] && (rsp_tdata == '0))
      else $error("short-range word not zero");

   a_sat_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> extreme_w)
      else $error("saturated flag without a clipped entry");

endmodule

bind radar_measurement_jacobian rmj_checker u_rmj_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for radar_measurement_jacobian: drives random and corner state
// words, predicts each Jacobian word with an exact-width integer model and checks every field.
// Depends on rmj_pkg and the radar_measurement_jacobian RTL.
`timescale 1ns / 100ps

module tb_top;

   typedef struct packed {
      logic [31:0] drange_dpx;
      logic [31:0] drange_dpy;
      logic [31:0] dbearing_dpx;
      logic [31:0] dbearing_dpy;
      logic [31:0] drate_dpx;
      logic [31:0] drate_dpy;
      logic        too_close;
      logic        saturated;
   } jac_word_type;

   localparam int SEND_IDLE_PCT = 0;
   localparam int WATCHDOG_LIMIT = 20000;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [rmj_pkg::REQ_W-1:0]    req_tdata = '0;
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [rmj_pkg::RSP_W-1:0]    rsp_tdata;
   logic [rmj_pkg::USER_W-1:0]   rsp_tuser;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [rmj_pkg::MIN_W-1:0]    csr_data = '0;

   logic [15:0]         min_range_shadow;
   jac_word_type        jacobian_q[$];
   int                  send_idle_pct;
   int                  rsp_stall_pct;
   int                  error_count = 0;
   int                  quiet_cycles = 0;

   radar_measurement_jacobian dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [31:0] clip_entry(input logic [191:0] mag, input logic neg,
                                              inout logic sat);
      logic [191:0] lim;
      lim = neg ? 192'h8000_0000 : 192'h7FFF_FFFF;
      if (mag > lim) begin
         sat = 1'b1;
         mag = lim;
      end
      return neg ? (32'd0 - mag[31:0]) : mag[31:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] s);
      logic [63:0] root;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         logic [63:0] t;
         t = root | (64'd1 << b);
         if (t * t <= s) root = t;
      end
      return root;
   endfunction

   function automatic jac_word_type predict_jacobian(input logic [rmj_pkg::REQ_W-1:0] word);
      jac_word_type   j;
      logic signed [63:0] p, q, vx, vy, c;
      logic [191:0]   ap, aq, ac, s, r, num;
      logic           cneg, sat;
      p  = $signed(word[31:0]);
      q  = $signed(word[63:32]);
      vx = $signed(word[95:64]);
      vy = $signed(word[127:96]);
      ap = p < 0 ? -p : p;
      aq = q < 0 ? -q : q;
      s  = ap * ap + aq * aq;
      r  = int_sqrt(s[63:0]);
      j  = '0;
      sat = 1'b0;
      if (r == 0 || r < min_range_shadow) begin
         j.too_close = 1'b1;
         return j;
      end
      c    = vx * q - vy * p;
      cneg = c < 0;
      ac   = cneg ? -c : c;
      j.drange_dpx   = clip_entry((ap << rmj_pkg::FRAC_BITS) / r, p < 0, sat);
      j.drange_dpy   = clip_entry((aq << rmj_pkg::FRAC_BITS) / r, q < 0, sat);
      j.dbearing_dpx = clip_entry((aq << (2 * rmj_pkg::FRAC_BITS)) / s, q > 0, sat);
      j.dbearing_dpy = clip_entry((ap << (2 * rmj_pkg::FRAC_BITS)) / s, p < 0, sat);
      num = (aq * ac) << rmj_pkg::FRAC_BITS;
      j.drate_dpx = clip_entry((num / s) / r, ((q < 0) != cneg) && aq != 0 && ac != 0, sat);
      num = (ap * ac) << rmj_pkg::FRAC_BITS;
      j.drate_dpy = clip_entry((num / s) / r, ((p < 0) == cneg) && ap != 0 && ac != 0, sat);
      j.saturated = sat;
      return j;
   endfunction

   // drive response backpressure and check each word
   always @(posedge clock) begin
      if (!reset) begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_tvalid && rsp_tready) begin
            jac_word_type got, want;
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[127:96],
                   rsp_tdata[159:128], rsp_tdata[191:160], rsp_tuser[0], rsp_tuser[1]};
            if (jacobian_q.size() == 0) begin
               $error("unexpected word");
               error_count++;
            end else begin
               want = jacobian_q.pop_front();
               if (got.drange_dpx !== want.drange_dpx) begin
                  $error("drange_dpx exp %h got %h", want.drange_dpx, got.drange_dpx);
                  error_count++;
               end
               if (got.drange_dpy !== want.drange_dpy) begin
                  $error("drange_dpy exp %h got %h", want.drange_dpy, got.drange_dpy);
                  error_count++;
               end
               if (got.dbearing_dpx !== want.dbearing_dpx) begin
                  $error("dbearing_dpx exp %h got %h", want.dbearing_dpx, got.dbearing_dpx);
                  error_count++;
               end
               if (got.dbearing_dpy !== want.dbearing_dpy) begin
                  $error("dbearing_dpy exp %h got %h", want.dbearing_dpy, got.dbearing_dpy);
                  error_count++;
               end
               if (got.drate_dpx !== want.drate_dpx) begin
                  $error("drate_dpx exp %h got %h", want.drate_dpx, got.drate_dpx);
                  error_count++;
               end
               if (got.drate_dpy !== want.drate_dpy) begin
                  $error("drate_dpy exp %h got %h", want.drate_dpy, got.drate_dpy);
                  error_count++;
               end
               if (got.too_close !== want.too_close) begin
                  $error("too_close exp %b got %b", want.too_close, got.too_close);
                  error_count++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated exp %b got %b", want.saturated, got.saturated);
                  error_count++;
               end
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
          || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_state(input logic [31:0] px, py, vx, vy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {vy, vx, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      jacobian_q.push_back(predict_jacobian({vy, vx, py, px}));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (jacobian_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_min_range(input logic [15:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      min_range_shadow = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $urandom_range(255) - 128;
         2: return {{16{$urandom_range(1) == 1}}, 16'($urandom)};
         3: return ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF) ^ $urandom_range(3);
         default: return $signed(24'($urandom));
      endcase
   endfunction

   task automatic test_corners();
      logic [31:0] ext[6];
      ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
      send_state(0, 0, 5, 5);
      send_state(1, 0, 0, 0);
      send_state(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_state(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++)
         send_state(ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6]);
      send_state(32'h0003_0000, 32'hFFFC_0000, 32'h0001_0000, 32'h0002_0000);
      send_state(0, 32'h0000_0002, 32'h7FFF_FFFF, 32'h8000_0000);
      send_state(32'hFFFF_FFFE, 0, 32'h8000_0000, 32'h7FFF_FFFF);
   endtask

   task automatic test_min_range();
      write_min_range(16'hFFFF);
      send_state(32'd65534, 0, 1, 1);
      send_state(32'd65535, 0, 1, 1);
      send_state(32'd46340, 32'd46341, 1, 2);
      write_min_range(16'd0);
      send_state(0, 0, 1, 1);
      send_state(1, 1, 32'hFFFF_FFFF, 1);
      write_min_range(16'd300);
      send_state(32'd299, 0, 0, 0);
      send_state(32'd300, 0, 0, 0);
   endtask

   task automatic test_random(input int count, input int idle, input int stall);
      send_idle_pct = idle;
      rsp_stall_pct = stall;
      for (int i = 0; i < count; i++)
         send_state(pick_coord(), pick_coord(), pick_coord(), pick_coord());
   endtask

   task automatic test_quiet_pause();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < 10; i++) send_state(pick_coord(), pick_coord(), $urandom, $urandom);
      drain_results();
      for (int i = 0; i < 10; i++) send_state(pick_coord(), pick_coord(), $urandom, $urandom);
   endtask

   initial begin
      min_range_shadow = 16'd1;
      send_idle_pct = SEND_IDLE_PCT;
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corners();
      test_min_range();
      write_min_range(16'd1);
      test_random(100, 0, 0);
      test_random(100, 69, 0);
      write_min_range(16'($urandom_range(65535)));
      test_random(100, 0, 69);
      test_quiet_pause();
      write_min_range(16'($urandom_range(200)));
      test_random(100, 30, 30);
      drain_results();
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
